>>> rtl/falru_pkg.sv
package falru_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_ENTRIES  = 512;
   localparam int DEF_TAG_BITS = 32;

   // Fixed field widths of the ports.
   localparam int CAP_W     = 10;
   localparam int COUNT_W   = 32;
   localparam int PORT_TAG_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 10'd512;

   // Match tree: each node ORs RADIX children, one register per level.
   localparam int RADIX_LOG = 3;
   localparam int RADIX     = 1 << RADIX_LOG;

   // Number of registered levels needed to reduce leaves down to one word.
   function automatic int tree_levels(input int leaves);
      int span;
      int lv;
      span = 1;
      lv   = 0;
      for (int k = 0; k < 8; k++) begin
         if (span < leaves) begin
            span = span << RADIX_LOG;
            lv   = lv + 1;
         end
      end
      if (lv == 0) begin
         lv = 1;
      end
      return lv;
   endfunction

   // Offset of the first node of a level in the flat node array.
   function automatic int level_offset(input int pad, input int level);
      int off;
      off = 0;
      for (int k = 0; k < level; k++) begin
         off = off + (pad >> (RADIX_LOG * (k + 1)));
      end
      return off;
   endfunction

endpackage

>>> rtl/falru_cell.sv
module falru_cell #(
   parameter int TAG_BITS = falru_pkg::DEF_TAG_BITS,
   parameter int IDX_W    = 9,
   parameter int OCC_W    = 10,
   parameter int INDEX    = 0
) (
   input  logic                        clock,
   input  logic                        update_en,
   input  logic [OCC_W-1:0]            shift_limit,
   input  logic [OCC_W-1:0]            occupancy,
   input  logic [TAG_BITS-1:0]         lookup_tag,
   input  logic [TAG_BITS-1:0]         prev_tag,
   output logic [TAG_BITS-1:0]         tag_out,
   output logic [IDX_W+TAG_BITS:0]     leaf_out
);

   logic [TAG_BITS-1:0] tag_ff;
   logic [TAG_BITS-1:0] tag_in;
   logic                match;
   logic                victim;

   // Take the neighbor's tag when this slot lies inside the shifted span.
   always_comb begin
      tag_in = tag_ff;
      if (update_en && (OCC_W'(INDEX) <= shift_limit)) begin
         tag_in = prev_tag;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   assign match  = (OCC_W'(INDEX) < occupancy) && (tag_ff == lookup_tag);
   assign victim = (OCC_W'(INDEX + 1) == occupancy);

   assign tag_out  = tag_ff;
   assign leaf_out = {match,
                      (match ? IDX_W'(INDEX) : {IDX_W{1'b0}}),
                      (victim ? tag_ff : {TAG_BITS{1'b0}})};

endmodule

>>> rtl/falru_or_tree.sv
module falru_or_tree #(
   parameter int LEAVES = falru_pkg::DEF_ENTRIES,
   parameter int WIDTH  = 42
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] leaf_in [LEAVES],
   output logic [WIDTH-1:0] root_out
);

   localparam int LEVELS = falru_pkg::tree_levels(LEAVES);
   localparam int PAD    = 1 << (falru_pkg::RADIX_LOG * LEVELS);
   localparam int NODES  = falru_pkg::level_offset(PAD, LEVELS);

   logic [WIDTH-1:0] leaf_pad [PAD];
   logic [WIDTH-1:0] node_ff  [NODES];

   // Pad unused leaves with zero.
   for (genvar p = 0; p < PAD; p++) begin : g_pad
      if (p < LEAVES) begin : g_real
         assign leaf_pad[p] = leaf_in[p];
      end else begin : g_zero
         assign leaf_pad[p] = '0;
      end
   end

   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      localparam int CNT     = PAD >> (falru_pkg::RADIX_LOG * (l + 1));
      localparam int OUT_OFF = falru_pkg::level_offset(PAD, l);
      for (genvar n = 0; n < CNT; n++) begin : g_node
         logic [WIDTH-1:0] node_in;
         if (l == 0) begin : g_first
            always_comb begin
               node_in = '0;
               for (int c = 0; c < falru_pkg::RADIX; c++) begin
                  node_in = node_in | leaf_pad[n * falru_pkg::RADIX + c];
               end
            end
         end else begin : g_upper
            localparam int IN_OFF = falru_pkg::level_offset(PAD, l - 1);
            always_comb begin
               node_in = '0;
               for (int c = 0; c < falru_pkg::RADIX; c++) begin
                  node_in = node_in | node_ff[IN_OFF + n * falru_pkg::RADIX + c];
               end
            end
         end
         always_ff @(posedge clock) begin
            node_ff[OUT_OFF + n] <= node_in;
         end
      end
   end

   assign root_out = node_ff[NODES-1];

endmodule

>>> rtl/fully_assoc_lru_tag_cache.sv
// Fully associative tag directory with least-recently-used replacement. Each
// request word carries one tag; the response word reports hit or miss, the
// tag evicted by a miss when the directory holds at least capacity_in_use
// entries (zero and values above ENTRIES act as 1 and ENTRIES), and the
// saturating hit and miss totals including this access. The entries sit in a
// row of cells in recency order, slot 0 the most recent; an update shifts a
// prefix of the row down by one cell and loads the new tag into slot 0. A
// word passes through an accept state, a search state that waits while the
// registered 8-ary OR tree collects the single matching slot and the least
// recent tag from all cells level by level, and an update state; the next
// word is accepted only once that update is done. The response
// register lets the next word be accepted and searched while a result still
// waits; the update stalls only if that result has not been taken. The tag
// store needs no clearing after reset: the occupancy count marks the valid
// slots. Configuration writes are taken at any edge with csr_wr_en high and
// are meant to happen while the block is idle.
module fully_assoc_lru_tag_cache #(
   parameter int ENTRIES  = falru_pkg::DEF_ENTRIES,
   parameter int TAG_BITS = falru_pkg::DEF_TAG_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [falru_pkg::PORT_TAG_W-1:0]  req_lookup_tag,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_was_hit,
   output logic                              rsp_evict_valid,
   output logic [falru_pkg::PORT_TAG_W-1:0]  rsp_evicted_tag,
   output logic [falru_pkg::COUNT_W-1:0]     rsp_hit_total,
   output logic [falru_pkg::COUNT_W-1:0]     rsp_miss_total,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [falru_pkg::CAP_W-1:0]       csr_wr_data
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CAPX_W = (OCC_W > falru_pkg::CAP_W) ? OCC_W : falru_pkg::CAP_W;
   localparam int WORD_W = 1 + IDX_W + TAG_BITS;
   localparam int LEVELS = falru_pkg::tree_levels(ENTRIES);
   localparam int CNT_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]    level_cnt_ff, level_cnt_in;
   logic [TAG_BITS-1:0] lookup_ff,    lookup_in;
   logic [OCC_W-1:0]    occ_ff,       occ_in;
   logic [falru_pkg::COUNT_W-1:0] hit_cnt_ff,  hit_cnt_in;
   logic [falru_pkg::COUNT_W-1:0] miss_cnt_ff, miss_cnt_in;
   logic [falru_pkg::CAP_W-1:0]   cap_ff,      cap_in;

   // response register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_hit_ff,   rsp_hit_in;
   logic                            rsp_evict_ff, rsp_evict_in;
   logic [falru_pkg::PORT_TAG_W-1:0] rsp_tag_ff,  rsp_tag_in;
   logic [falru_pkg::COUNT_W-1:0]   rsp_hits_ff,  rsp_hits_in;
   logic [falru_pkg::COUNT_W-1:0]   rsp_miss_ff,  rsp_miss_in;

   logic [TAG_BITS-1:0] cell_tag  [ENTRIES];
   logic [WORD_W-1:0]   cell_leaf [ENTRIES];
   logic [WORD_W-1:0]   root;

   logic                root_hit;
   logic [IDX_W-1:0]    root_idx;
   logic [TAG_BITS-1:0] root_victim;
   logic [CAPX_W-1:0]   cap_eff;
   logic                full;
   logic                commit;
   logic [OCC_W-1:0]    shift_limit;

   assign root_hit    = root[WORD_W-1];
   assign root_idx    = root[TAG_BITS +: IDX_W];
   assign root_victim = root[TAG_BITS-1:0];

   // Clamp the capacity register into 1..ENTRIES.
   always_comb begin
      cap_eff = CAPX_W'(cap_ff);
      if (cap_eff == '0) begin
         cap_eff = CAPX_W'(1);
      end else if (cap_eff > CAPX_W'(ENTRIES)) begin
         cap_eff = CAPX_W'(ENTRIES);
      end
   end

   assign full   = (CAPX_W'(occ_ff) >= cap_eff);
   assign commit = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   // Last slot that takes its upper neighbor's tag: the hit slot, the least
   // recent slot on an eviction, or one past the end on a plain insert.
   always_comb begin
      if (root_hit) begin
         shift_limit = OCC_W'(root_idx);
      end else if (full) begin
         shift_limit = occ_ff - OCC_W'(1);
      end else begin
         shift_limit = occ_ff;
      end
   end

   // Row of recency cells; slot 0 is fed with the looked-up tag.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [TAG_BITS-1:0] prev_tag;
      if (i == 0) begin : g_head
         assign prev_tag = lookup_ff;
      end else begin : g_body
         assign prev_tag = cell_tag[i-1];
      end
      falru_cell #(
         .TAG_BITS (TAG_BITS),
         .IDX_W    (IDX_W),
         .OCC_W    (OCC_W),
         .INDEX    (i)
      ) u_cell (
         .clock       (clock),
         .update_en   (commit),
         .shift_limit (shift_limit),
         .occupancy   (occ_ff),
         .lookup_tag  (lookup_ff),
         .prev_tag    (prev_tag),
         .tag_out     (cell_tag[i]),
         .leaf_out    (cell_leaf[i])
      );
   end

   // Collect the one matching slot and the least recent tag.
   falru_or_tree #(
      .LEAVES (ENTRIES),
      .WIDTH  (WORD_W)
   ) u_tree (
      .clock    (clock),
      .leaf_in  (cell_leaf),
      .root_out (root)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      level_cnt_in = level_cnt_ff;
      lookup_in    = lookup_ff;
      occ_in       = occ_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_evict_in = rsp_evict_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_hits_in  = rsp_hits_ff;
      rsp_miss_in  = rsp_miss_ff;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               lookup_in    = TAG_BITS'(req_lookup_tag);
               level_cnt_in = '0;
               state_in     = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // hold while the tree levels settle
            level_cnt_in = level_cnt_ff + CNT_W'(1);
            if (level_cnt_ff == CNT_W'(LEVELS - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (commit) begin
               if (root_hit) begin
                  if (hit_cnt_ff != '1) begin
                     hit_cnt_in = hit_cnt_ff + falru_pkg::COUNT_W'(1);
                  end
               end else begin
                  if (miss_cnt_ff != '1) begin
                     miss_cnt_in = miss_cnt_ff + falru_pkg::COUNT_W'(1);
                  end
                  if (!full) begin
                     occ_in = occ_ff + OCC_W'(1);
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_hit_in   = root_hit;
               rsp_evict_in = !root_hit && full;
               rsp_tag_in   = (!root_hit && full) ?
                              falru_pkg::PORT_TAG_W'(root_victim) : '0;
               rsp_hits_in  = hit_cnt_in;
               rsp_miss_in  = miss_cnt_in;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_cnt_ff <= '0;
         occ_ff       <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         cap_ff       <= falru_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_cnt_ff <= level_cnt_in;
         occ_ff       <= occ_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lookup_ff    <= lookup_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_evict_ff <= rsp_evict_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_hits_ff  <= rsp_hits_in;
      rsp_miss_ff  <= rsp_miss_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_was_hit     = rsp_hit_ff;
   assign rsp_evict_valid = rsp_evict_ff;
   assign rsp_evicted_tag = rsp_tag_ff;
   assign rsp_hit_total   = rsp_hits_ff;
   assign rsp_miss_total  = rsp_miss_ff;

endmodule

>>> rtl/falru_checker.sv
module falru_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_was_hit,
   input logic                              rsp_evict_valid,
   input logic [falru_pkg::PORT_TAG_W-1:0]  rsp_evicted_tag,
   input logic [falru_pkg::COUNT_W-1:0]     rsp_hit_total,
   input logic [falru_pkg::COUNT_W-1:0]     rsp_miss_total
);

   // no response word right after reset
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_was_hit)
         && $stable(rsp_evict_valid) && $stable(rsp_evicted_tag)
         && $stable(rsp_hit_total) && $stable(rsp_miss_total))
      else $error("stalled response changed");

   // a hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_was_hit && rsp_evict_valid))
      else $error("eviction reported on a hit");

   // evicted tag reads zero without an eviction
   a_tag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evict_valid |-> rsp_evicted_tag == '0)
      else $error("evicted tag nonzero without eviction");

   // every word counts as a hit or a miss
   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_was_hit ? (rsp_hit_total != '0) : (rsp_miss_total != '0)))
      else $error("running total missed this access");

endmodule

bind fully_assoc_lru_tag_cache falru_checker u_falru_checker (.*);
